FILE: hdl/wfp_pkg.sv
package wfp_pkg;

  localparam int QW       = 94;
  localparam int XN       = 16;
  localparam int PIPE_LAT = 3 + QW + XN + 1;

  localparam logic [63:0] OVF         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_Q32     = 64'h0000_0002_0000_0000;
  localparam logic [63:0] OUT_POS_MAG = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] OUT_NEG_MAG = 64'h0000_8000_0000_0000;

  typedef enum logic [1:0] {
    CFG_SIGMA  = 2'd0,
    CFG_CUTOFF = 2'd1,
    CFG_DEPTH  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        xneg;
    logic        yneg;
    logic        noint;
    logic [30:0] ax;
    logic [30:0] ay;
  } front_t;

  typedef struct packed {
    front_t      f;
    logic        aneg;
    logic        ineg;
    logic        br1;
    logic        br2pos;
    logic [63:0] p;
    logic [63:0] c;
    logic [63:0] k;
    logic [63:0] am;
    logic [63:0] inner;
    logic [63:0] cc;
    logic [63:0] w;
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] e;
  } ctx_t;

  typedef struct packed {
    logic [47:0] fx;
    logic [47:0] fy;
    logic [47:0] en;
    logic        noint;
    logic        sat;
  } res_t;

  function automatic logic [63:0] sadd(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (x == OVF || y == OVF || s[64]) return OVF;
    return s[63:0];
  endfunction

  function automatic logic [48:0] pack_out(input logic [63:0] mag, input logic neg);
    logic [63:0] mc;
    logic [63:0] tc;
    logic        sat;
    sat = 1'b0;
    mc  = mag;
    if (neg) begin
      if (mag > OUT_NEG_MAG) begin
        mc  = OUT_NEG_MAG;
        sat = 1'b1;
      end
      tc = ~mc + 64'd1;
    end else begin
      if (mag > OUT_POS_MAG) begin
        mc  = OUT_POS_MAG;
        sat = 1'b1;
      end
      tc = mc;
    end
    return {sat, tc[47:0]};
  endfunction

endpackage

FILE: hdl/wfp_if.sv
interface wfp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_i_x;
  logic [31:0] pos_i_y;
  logic [31:0] pos_j_x;
  logic [31:0] pos_j_y;
  modport source (output valid, pos_i_x, pos_i_y, pos_j_x, pos_j_y, input ready);
  modport sink (input valid, pos_i_x, pos_i_y, pos_j_x, pos_j_y, output ready);
endinterface

interface wfp_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] force_x;
  logic [47:0] force_y;
  logic [47:0] pair_energy;
  logic        no_interaction;
  logic        saturated;
  modport source (output valid, force_x, force_y, pair_energy, no_interaction, saturated,
                  input ready);
  modport sink (input valid, force_x, force_y, pair_energy, no_interaction, saturated,
                output ready);
endinterface

FILE: hdl/wfp_div.sv
module wfp_div #(
  parameter int NW = 94,
  parameter int DW = 63
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem [NW-1];
  logic [DW-1:0] dn  [NW-1];
  logic [NW-1:0] nq  [NW];

  for (genvar j = 0; j < NW; j++) begin : g_step
    logic [DW-1:0] rp;
    logic [DW-1:0] dp;
    logic [NW-1:0] qp;
    logic [DW:0]   t;
    logic [DW:0]   d;
    logic          ge;
    if (j == 0) begin : g_first
      assign rp = '0;
      assign dp = den;
      assign qp = num;
    end else begin : g_rest
      assign rp = rem[j-1];
      assign dp = dn[j-1];
      assign qp = nq[j-1];
    end
    assign t  = {rp, qp[NW-1]};
    assign ge = t >= {1'b0, dp};
    assign d  = t - {1'b0, dp};
    always_ff @(posedge clk) begin
      if (en) begin
        nq[j] <= {qp[NW-2:0], ge};
      end
    end
    if (j < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= ge ? d[DW-1:0] : t[DW-1:0];
          dn[j]  <= dp;
        end
      end
    end
  end

  assign quo = nq[NW-1];

endmodule

FILE: hdl/wfp_mulq.sv
module wfp_mulq (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);
  import wfp_pkg::*;

  logic [63:0]  ll, lh, hl, hh, hh2;
  logic         z1, o1, z2, o2;
  logic [96:0]  lo2;
  logic [127:0] full;

  assign full = {hh2, 64'd0} + {31'd0, lo2};

  always_ff @(posedge clk) begin
    if (en) begin
      ll  <= a[31:0] * b[31:0];
      lh  <= a[31:0] * b[63:32];
      hl  <= a[63:32] * b[31:0];
      hh  <= a[63:32] * b[63:32];
      z1  <= (a == 64'd0) || (b == 64'd0);
      o1  <= (a == OVF) || (b == OVF);
      lo2 <= {33'd0, ll} + {1'b0, lh, 32'd0} + {1'b0, hl, 32'd0};
      hh2 <= hh;
      z2  <= z1;
      o2  <= o1;
      if (z2) y <= 64'd0;
      else if (o2 || (|full[127:96])) y <= OVF;
      else y <= full[95:32];
    end
  end

endmodule

FILE: hdl/wang_frenkel_pair_interaction.sv
// Throughput: one pair per cycle; the whole pipeline advances together and
// halts only while a result waits at the output.
// Depth is set by the 94-stage bit-per-stage division pipeline.
// Reset (rst, synchronous) clears all valid bits and restores the registers
// to sigma 1.0, cutoff 3.0 and well depth 1.0.
module wang_frenkel_pair_interaction (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  wfp_in_if.sink      pairs,
  wfp_out_if.source   results
);
  import wfp_pkg::*;

  logic [30:0] sigma_length, cutoff_radius, well_depth;
  logic [61:0] sq_sigma, sq_cut;
  logic        adv;
  logic [PIPE_LAT-1:0] vs;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_length  <= 31'd65536;
      cutoff_radius <= 31'd196608;
      well_depth    <= 31'd65536;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SIGMA:  sigma_length  <= cfg_data;
        CFG_CUTOFF: cutoff_radius <= cfg_data;
        CFG_DEPTH:  well_depth    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sq_sigma <= sigma_length * sigma_length;
    sq_cut   <= cutoff_radius * cutoff_radius;
  end

  assign adv         = !vs[PIPE_LAT-1] || results.ready;
  assign pairs.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (adv) begin
      vs <= {vs[PIPE_LAT-2:0], pairs.valid};
    end
  end

  logic [32:0] dx, dy;
  logic [32:0] ax1, ay1;
  logic        xn1, yn1, xn2, yn2, far2;
  logic [30:0] ax2, ay2;
  logic [61:0] sx2, sy2;
  logic [62:0] d2;
  front_t      f3;

  assign dx = {pairs.pos_i_x[31], pairs.pos_i_x} - {pairs.pos_j_x[31], pairs.pos_j_x};
  assign dy = {pairs.pos_i_y[31], pairs.pos_i_y} - {pairs.pos_j_y[31], pairs.pos_j_y};

  always_ff @(posedge clk) begin
    if (adv) begin
      xn1  <= dx[32];
      yn1  <= dy[32];
      ax1  <= dx[32] ? (~dx + 33'd1) : dx;
      ay1  <= dy[32] ? (~dy + 33'd1) : dy;
      xn2  <= xn1;
      yn2  <= yn1;
      far2 <= (ax1 >= {2'b00, cutoff_radius}) || (ay1 >= {2'b00, cutoff_radius});
      ax2  <= ax1[30:0];
      ay2  <= ay1[30:0];
      sx2  <= ax1[30:0] * ax1[30:0];
      sy2  <= ay1[30:0] * ay1[30:0];
      d2   <= {1'b0, sx2} + {1'b0, sy2};
      f3.xneg  <= xn2;
      f3.yneg  <= yn2;
      f3.noint <= far2 || ({1'b0, sx2} + {1'b0, sy2} == 63'd0) ||
                  ({1'b0, sx2} + {1'b0, sy2} >= {1'b0, sq_cut});
      f3.ax    <= ax2;
      f3.ay    <= ay2;
    end
  end

  logic [QW-1:0] qp, qq, qk;

  wfp_div #(.NW(QW), .DW(63)) u_div_p (
    .clk(clk), .en(adv), .num({sq_sigma, 32'd0}), .den(d2), .quo(qp));
  wfp_div #(.NW(QW), .DW(63)) u_div_q (
    .clk(clk), .en(adv), .num({sq_cut, 32'd0}), .den(d2), .quo(qq));
  wfp_div #(.NW(QW), .DW(63)) u_div_k (
    .clk(clk), .en(adv), .num({15'd0, well_depth, 48'd0}), .den(d2), .quo(qk));

  front_t fr [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      fr[0] <= f3;
      for (int i = 1; i < QW; i++) fr[i] <= fr[i-1];
    end
  end

  ctx_t cx [XN];
  ctx_t cx_next [XN];
  logic [63:0] y1a, y1b, y1c, y2a, y2b, y3a, y3b, y4a, y4b;
  logic [63:0] t1;

  wfp_mulq u_m1a (.clk(clk), .en(adv), .a(cx[0].p),  .b(cx[0].c),  .y(y1a));
  wfp_mulq u_m1b (.clk(clk), .en(adv), .a(cx[0].inner), .b(t1),  .y(y1b));
  wfp_mulq u_m1c (.clk(clk), .en(adv), .a(cx[0].c),  .b(cx[0].c),  .y(y1c));
  wfp_mulq u_m2a (.clk(clk), .en(adv), .a(cx[4].c),  .b(cx[4].inner), .y(y2a));
  wfp_mulq u_m2b (.clk(clk), .en(adv), .a(cx[4].am), .b(cx[4].cc), .y(y2b));
  wfp_mulq u_m3a (.clk(clk), .en(adv), .a(cx[8].w),  .b(cx[8].k),  .y(y3a));
  wfp_mulq u_m3b (.clk(clk), .en(adv), .a({33'd0, well_depth}), .b(cx[8].m), .y(y3b));
  wfp_mulq u_m4a (.clk(clk), .en(adv), .a(cx[12].v), .b({33'd0, cx[12].f.ax}), .y(y4a));
  wfp_mulq u_m4b (.clk(clk), .en(adv), .a(cx[12].v), .b({33'd0, cx[12].f.ay}), .y(y4b));

  // cx[0].inner carries q until the first multiply level; cx[0].cc carries t
  assign t1 = cx[0].cc;

  always_comb begin
    logic [63:0] p, q, k;
    logic [33:0] p3;
    logic        b1, b2;
    p = ((|qp[QW-1:64]) || qp[63:0] == OVF) ? OVF : qp[63:0];
    q = ((|qq[QW-1:64]) || qq[63:0] == OVF) ? OVF : qq[63:0];
    k = ((|qk[QW-1:64]) || qk[63:0] == OVF) ? OVF : qk[63:0];
    p3 = {p[31:0], 1'b0} + {2'b00, p[31:0]};
    b1 = p >= ONE_Q32;
    b2 = p3 >= TWO_Q32[33:0];
    for (int i = 1; i < XN; i++) cx_next[i] = cx[i-1];
    cx_next[0]        = '0;
    cx_next[0].f      = fr[QW-1];
    cx_next[0].p      = p;
    cx_next[0].k      = k;
    cx_next[0].c      = (q == OVF) ? OVF : q - ONE_Q32;
    cx_next[0].br1    = b1;
    cx_next[0].br2pos = b2;
    cx_next[0].aneg   = !b1;
    cx_next[0].am     = b1 ? ((p == OVF) ? OVF : p - ONE_Q32) : ONE_Q32 - p;
    cx_next[0].inner  = q;
    if (b1) cx_next[0].cc = cx_next[0].am;
    else if (b2) cx_next[0].cc = {30'd0, p3} - TWO_Q32;
    else cx_next[0].cc = TWO_Q32 - {30'd0, p3};

    cx_next[4].cc = y1c;
    if (cx[3].br1) begin
      cx_next[4].inner = sadd(y1a, sadd(y1b, y1b));
      cx_next[4].ineg  = 1'b0;
    end else if (cx[3].br2pos) begin
      if (y1b == OVF) begin
        cx_next[4].inner = OVF;
        cx_next[4].ineg  = 1'b0;
      end else if (y1b >= cx[3].p) begin
        cx_next[4].inner = y1b - cx[3].p;
        cx_next[4].ineg  = 1'b0;
      end else begin
        cx_next[4].inner = cx[3].p - y1b;
        cx_next[4].ineg  = 1'b1;
      end
    end else begin
      cx_next[4].inner = sadd(y1b, cx[3].p);
      cx_next[4].ineg  = 1'b1;
    end

    cx_next[8].w = y2a;
    cx_next[8].m = y2b;

    cx_next[12].v = sadd(y3a, y3a);
    cx_next[12].e = y3b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < XN; i++) cx[i] <= cx_next[i];
    end
  end

  res_t res, res_next;

  always_comb begin
    logic [48:0] px, py, pe;
    px = pack_out(y4a, cx[15].f.xneg ^ cx[15].ineg);
    py = pack_out(y4b, cx[15].f.yneg ^ cx[15].ineg);
    pe = pack_out(cx[15].e, cx[15].aneg);
    if (cx[15].f.noint) begin
      res_next = '0;
      res_next.noint = 1'b1;
    end else begin
      res_next.fx    = px[47:0];
      res_next.fy    = py[47:0];
      res_next.en    = pe[47:0];
      res_next.noint = 1'b0;
      res_next.sat   = px[48] | py[48] | pe[48];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res <= res_next;
  end

  assign results.valid          = vs[PIPE_LAT-1];
  assign results.force_x        = res.fx;
  assign results.force_y        = res.fy;
  assign results.pair_energy    = res.en;
  assign results.no_interaction = res.noint;
  assign results.saturated      = res.sat;

endmodule

FILE: hdl/wfp_checker.sv
module wfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] force_x,
  input logic [47:0] force_y,
  input logic [47:0] pair_energy,
  input logic        no_interaction,
  input logic        saturated
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(pair_energy))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

  a_noint: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_interaction |->
      force_x == 48'd0 && force_y == 48'd0 && pair_energy == 48'd0 && !saturated)
    else $error("non-interacting pair with nonzero result");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("transaction taken while output stalled");

endmodule

bind wang_frenkel_pair_interaction wfp_checker u_wfp_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(pairs.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .force_x(results.force_x),
  .force_y(results.force_y),
  .pair_energy(results.pair_energy),
  .no_interaction(results.no_interaction),
  .saturated(results.saturated)
);
